// File: rtl/cfdr_pkg.sv
package cfdr_pkg;

  // Bytes with a meaning to the framer
  localparam logic [7:0] FRAME_OPEN  = 8'h02;
  localparam logic [7:0] FRAME_CLOSE = 8'h03;
  localparam logic [7:0] TEXT_OPEN   = 8'h21;
  localparam logic [7:0] TEXT_CLOSE  = 8'h0A;
  localparam logic [8:0] FRAME_OVERHEAD = 9'd4;

  // Result event codes
  localparam logic [2:0] EV_NONE       = 3'd0;
  localparam logic [2:0] EV_FRAME_BYTE = 3'd1;
  localparam logic [2:0] EV_TEXT_BYTE  = 3'd2;
  localparam logic [2:0] EV_FRAME_OK   = 3'd3;
  localparam logic [2:0] EV_CRC_BAD    = 3'd4;
  localparam logic [2:0] EV_FRAME_LONG = 3'd5;
  localparam logic [2:0] EV_LINE_END   = 3'd6;
  localparam logic [2:0] EV_LINE_LONG  = 3'd7;

  // Configuration register indexes
  localparam logic [1:0] CFG_CRC_POLY  = 2'd0;
  localparam logic [1:0] CFG_CRC_INIT  = 2'd1;
  localparam logic [1:0] CFG_ECHO_EN   = 2'd2;

  typedef struct packed {
    logic frame_open;
    logic frame_close;
    logic text_open;
    logic text_close;
  } byte_class_t;

  typedef struct packed {
    logic [7:0]  data;
    byte_class_t cls;
  } item_t;

  typedef struct packed {
    logic       echo_valid;
    logic [7:0] echo_byte;
    logic [2:0] event_res;
    logic [7:0] data_byte;
    logic [4:0] data_index;
    logic [7:0] frame_command;
    logic [4:0] frame_length;
  } result_t;

endpackage

// File: rtl/cfdr_front.sv
module cfdr_front import cfdr_pkg::*; (
  input  logic       push,
  input  logic [7:0] byte_in,
  input  logic       q_full,
  output logic       q_push,
  output item_t      q_item
);

  assign q_push = push & ~q_full;

  always_comb begin
    q_item.data            = byte_in;
    q_item.cls.frame_open  = (byte_in == FRAME_OPEN);
    q_item.cls.frame_close = (byte_in == FRAME_CLOSE);
    q_item.cls.text_open   = (byte_in == TEXT_OPEN);
    q_item.cls.text_close  = (byte_in == TEXT_CLOSE);
  end

endmodule

// File: rtl/cfdr_queue.sv
module cfdr_queue import cfdr_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t wr_item,
  output logic  full,
  input  logic  pop,
  output item_t rd_item,
  output logic  empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  item_t           entries [DEPTH];
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r,  count_nxt;
  logic            do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign rd_item = entries[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    priority if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end else begin
      count_nxt = count_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr_r] <= wr_item;
    end
  end

endmodule

// File: rtl/cfdr_back.sv
module cfdr_back import cfdr_pkg::*; #(
  parameter int MAX_MESSAGE_BYTES = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  // classified bytes from the queue
  input  logic       q_empty,
  input  item_t      q_item,
  output logic       q_pop,
  // configuration
  input  logic       cfg_valid,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  // result register
  output logic       res_valid,
  output result_t    res,
  input  logic       res_pop
);

  localparam int PosW = $clog2(MAX_MESSAGE_BYTES);
  localparam logic [8:0] MaxBytes = 9'(MAX_MESSAGE_BYTES);

  localparam logic [2:0] MODE_IDLE   = 3'd0;
  localparam logic [2:0] MODE_LENGTH = 3'd1;
  localparam logic [2:0] MODE_TEXT   = 3'd2;
  localparam logic [2:0] MODE_BODY   = 3'd3;
  localparam logic [2:0] MODE_STOP   = 3'd4;

  logic [7:0]      crc_poly_r, crc_init_r;
  logic            echo_en_r;

  logic [2:0]      mode_r,    mode_nxt;
  logic [PosW-1:0] pos_r,     pos_nxt;
  logic [PosW-1:0] total_r,   total_nxt;
  logic [7:0]      crc_r,     crc_nxt;
  logic            matched_r, matched_nxt;
  logic [7:0]      cmd_r,     cmd_nxt;

  result_t         res_r, res_nxt;
  logic            res_valid_r;

  logic            take;
  logic [7:0]      b;
  logic [7:0]      crc_src, crc_new;
  logic [8:0]      total9, pos9, pos9_inc;
  logic [PosW:0]   pos_inc;

  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] d,
                                           input logic [7:0] poly);
    logic [7:0] c;
    c = crc ^ d;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ poly) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

  // advance when a byte waits and the result slot is free or being drained
  assign take      = ~q_empty & (~res_valid_r | res_pop);
  assign q_pop     = take;
  assign res_valid = res_valid_r;
  assign res       = res_r;

  assign b        = q_item.data;
  assign crc_src  = (mode_r == MODE_IDLE) ? crc_init_r : crc_r;
  assign crc_new  = crc8_step(crc_src, b, crc_poly_r);
  assign total9   = {1'b0, b} + FRAME_OVERHEAD;
  assign pos9     = {{(9 - PosW){1'b0}}, pos_r};
  assign pos9_inc = pos9 + 9'd1;
  assign pos_inc  = {1'b0, pos_r} + 1'b1;

  always_comb begin
    mode_nxt    = mode_r;
    pos_nxt     = pos_r;
    total_nxt   = total_r;
    crc_nxt     = crc_r;
    matched_nxt = matched_r;
    cmd_nxt     = cmd_r;

    res_nxt               = '0;
    res_nxt.echo_valid    = echo_en_r;
    res_nxt.echo_byte     = b;
    res_nxt.event_res     = EV_NONE;

    unique case (mode_r)
      MODE_IDLE: begin
        if (q_item.cls.frame_open) begin
          pos_nxt            = PosW'(1);
          crc_nxt            = crc_new;
          matched_nxt        = (crc_init_r == b);
          res_nxt.event_res  = EV_FRAME_BYTE;
          res_nxt.data_byte  = b;
          mode_nxt           = MODE_LENGTH;
        end else if (q_item.cls.text_open) begin
          pos_nxt  = '0;
          mode_nxt = MODE_TEXT;
        end
      end
      MODE_LENGTH: begin
        if (total9 >= MaxBytes) begin
          res_nxt.event_res = EV_FRAME_LONG;
          pos_nxt           = '0;
          total_nxt         = '0;
          mode_nxt          = MODE_IDLE;
        end else begin
          res_nxt.event_res  = EV_FRAME_BYTE;
          res_nxt.data_byte  = b;
          res_nxt.data_index = pos9[4:0];
          matched_nxt        = (crc_r == b);
          crc_nxt            = crc_new;
          pos_nxt            = pos_inc[PosW-1:0];
          total_nxt          = total9[PosW-1:0];
          mode_nxt           = MODE_BODY;
        end
      end
      MODE_TEXT: begin
        if (pos9_inc >= MaxBytes) begin
          // line would overflow the buffer: drop it
          res_nxt.event_res = EV_LINE_LONG;
          pos_nxt           = '0;
          mode_nxt          = MODE_IDLE;
        end else if (!q_item.cls.text_close) begin
          res_nxt.event_res  = EV_TEXT_BYTE;
          res_nxt.data_byte  = b;
          res_nxt.data_index = pos9[4:0];
          pos_nxt            = pos_inc[PosW-1:0];
        end else begin
          res_nxt.event_res    = EV_LINE_END;
          res_nxt.frame_length = pos9[4:0];
          pos_nxt              = '0;
          mode_nxt             = MODE_IDLE;
        end
      end
      MODE_BODY: begin
        if (pos_r < total_r) begin
          if (pos_r == PosW'(2)) begin
            cmd_nxt = b;
          end
          res_nxt.event_res  = EV_FRAME_BYTE;
          res_nxt.data_byte  = b;
          res_nxt.data_index = pos9[4:0];
          matched_nxt        = (crc_r == b);
          crc_nxt            = crc_new;
          pos_nxt            = pos_inc[PosW-1:0];
          if (pos_inc >= {1'b0, total_r}) begin
            mode_nxt = MODE_STOP;
          end
        end else begin
          pos_nxt   = '0;
          total_nxt = '0;
          mode_nxt  = MODE_IDLE;
        end
      end
      MODE_STOP: begin
        // ignore everything until the close byte
        if (q_item.cls.frame_close) begin
          res_nxt.frame_length = pos9[4:0];
          if (pos_r == total_r && matched_r) begin
            res_nxt.event_res     = EV_FRAME_OK;
            res_nxt.frame_command = cmd_r;
          end else begin
            res_nxt.event_res = EV_CRC_BAD;
          end
          pos_nxt  = '0;
          mode_nxt = MODE_IDLE;
        end
      end
      default: begin
        pos_nxt   = '0;
        total_nxt = '0;
        mode_nxt  = MODE_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_poly_r  <= 8'h2D;
      crc_init_r  <= 8'h00;
      echo_en_r   <= 1'b1;
      mode_r      <= MODE_IDLE;
      pos_r       <= '0;
      total_r     <= '0;
      crc_r       <= '0;
      matched_r   <= 1'b0;
      cmd_r       <= '0;
      res_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_CRC_POLY: crc_poly_r <= cfg_data;
          CFG_CRC_INIT: crc_init_r <= cfg_data;
          CFG_ECHO_EN:  echo_en_r  <= cfg_data[0];
          default: ;
        endcase
      end
      if (take) begin
        mode_r    <= mode_nxt;
        pos_r     <= pos_nxt;
        total_r   <= total_nxt;
        crc_r     <= crc_nxt;
        matched_r <= matched_nxt;
        cmd_r     <= cmd_nxt;
      end
      if (take) begin
        res_valid_r <= 1'b1;
      end else if (res_pop) begin
        res_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_r <= res_nxt;
    end
  end

endmodule

// File: rtl/crc_framed_datagram_receiver.sv
// Receiver for STX/ETX length-framed datagrams checked by a CRC-8, and for
// '!'-opened text lines. Every accepted byte yields exactly one result with
// an echo copy and an event code. Bytes are taken at one per clock while in_full
// is low: the front end classifies each byte into a queue of QUEUE_DEPTH
// entries, and the back end runs the framing state and a full 8-bit CRC step
// on one byte per cycle, while the result slot is free or being drained, into
// a single result register. A byte passes through a queue entry and then the
// result register; a stalled result side absorbs QUEUE_DEPTH + 1 bytes before
// in_full rises. Configuration writes are taken in any cycle (cfg_ready is
// tied high) and belong where no byte is in flight.
module crc_framed_datagram_receiver import cfdr_pkg::*; #(
  parameter int MAX_MESSAGE_BYTES = 32,
  parameter int QUEUE_DEPTH       = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  // input channel
  input  logic       in_push,
  input  logic [7:0] in_byte_in,
  output logic       in_full,
  // result channel
  output logic       out_empty,
  input  logic       out_pop,
  output logic       out_echo_valid,
  output logic [7:0] out_echo_byte,
  output logic [2:0] out_event_res,
  output logic [7:0] out_data_byte,
  output logic [4:0] out_data_index,
  output logic [7:0] out_frame_command,
  output logic [4:0] out_frame_length,
  // configuration write channel
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  logic    q_push, q_pop, q_full, q_empty;
  item_t   q_wr_item, q_rd_item;
  logic    res_valid;
  result_t res;

  assign cfg_ready = 1'b1;
  assign in_full   = q_full;

  cfdr_front u_front (
    .push    (in_push),
    .byte_in (in_byte_in),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_item  (q_wr_item)
  );

  cfdr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_item (q_wr_item),
    .full    (q_full),
    .pop     (q_pop),
    .rd_item (q_rd_item),
    .empty   (q_empty)
  );

  cfdr_back #(
    .MAX_MESSAGE_BYTES (MAX_MESSAGE_BYTES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_item    (q_rd_item),
    .q_pop     (q_pop),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .res_valid (res_valid),
    .res       (res),
    .res_pop   (out_pop)
  );

  assign out_empty         = ~res_valid;
  assign out_echo_valid    = res.echo_valid;
  assign out_echo_byte     = res.echo_byte;
  assign out_event_res     = res.event_res;
  assign out_data_byte     = res.data_byte;
  assign out_data_index    = res.data_index;
  assign out_frame_command = res.frame_command;
  assign out_frame_length  = res.frame_length;

  // Both sides come up drained after reset
  a_reset_drained: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> out_empty && !in_full)
    else $error("queue or result register not drained after reset");

  // The queue fills only from an input transfer
  a_full_after_push: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_full) |-> $past(in_push && !in_full))
    else $error("in_full rose without an input transfer");

  // Stored-byte fields are zero outside byte events
  a_data_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_event_res != EV_FRAME_BYTE && out_event_res != EV_TEXT_BYTE)
      |-> (out_data_byte == 8'd0 && out_data_index == 5'd0))
    else $error("data fields set on a non-byte event");

  // The command is reported only with a good frame
  a_command_field: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_event_res != EV_FRAME_OK) |-> out_frame_command == 8'd0)
    else $error("frame command set without a good frame");

endmodule
